// ===== rtl/trr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TFTP read receiver package
// Shared types and protocol codes for the read-transfer receiver.
// ----------------------------------------------------------------------------
package trr_pkg;

   // event kinds on the request channel
   typedef enum logic [1:0] {
      REQ_START   = 2'd0,
      REQ_PACKET  = 2'd1,
      REQ_TIMEOUT = 2'd2
   } req_kind_type;

   // TFTP opcodes of interest
   localparam logic [15:0] OP_DATA  = 16'd3;
   localparam logic [15:0] OP_ERROR = 16'd5;
   localparam logic [15:0] OP_OACK  = 16'd6;

   typedef enum logic [2:0] {
      ACT_NONE        = 3'd0,
      ACT_ACK         = 3'd1,
      ACT_RRQ         = 3'd2,
      ACT_UNKNOWN_ID  = 3'd3,
      ACT_BAD_OPTIONS = 3'd4
   } action_type;

   // register indexes on the csr channel
   localparam int unsigned CsrIdxWidth = 2;
   localparam logic [CsrIdxWidth-1:0] CSR_INITIAL_BLOCK_SIZE = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_RETRIES        = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_OPTIONS_REQUESTED  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_TSIZE_REQUESTED    = 2'd3;

   localparam logic [15:0] BLOCK_SIZE_RESET  = 16'd512;
   localparam logic [7:0]  MAX_RETRIES_RESET = 8'd5;

   typedef struct packed {
      logic [15:0] initial_block_size;
      logic [7:0]  max_retries;
      logic        options_requested;
      logic        tsize_requested;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] opcode;
      logic [15:0] blk_num;
      logic [15:0] payload_len;
      logic        packet_empty;
      logic [47:0] peer_addr;
      logic [15:0] oack_block_size;
      logic        oack_unrequested;
      logic [31:0] oack_tsize;
   } req_item_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] ack_block;
      logic [15:0] write_len;
      logic        done_res;
      logic        failed;
      logic        may_lack_options;
   } rsp_item_type;

endpackage : trr_pkg
`default_nettype wire

// ===== rtl/trr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TFTP read receiver channel interfaces
// Valid/ready channels for request words, result words and csr writes.
// ----------------------------------------------------------------------------
interface trr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] opcode;
   logic [15:0] blk_num;
   logic [15:0] payload_len;
   logic        packet_empty;
   logic [47:0] peer_addr;
   logic [15:0] oack_block_size;
   logic        oack_unrequested;
   logic [31:0] oack_tsize;

   modport source (
      output valid, req_type, opcode, blk_num, payload_len, packet_empty,
             peer_addr, oack_block_size, oack_unrequested, oack_tsize,
      input  ready
   );
   modport sink (
      input  valid, req_type, opcode, blk_num, payload_len, packet_empty,
             peer_addr, oack_block_size, oack_unrequested, oack_tsize,
      output ready
   );
endinterface : trr_req_if

interface trr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] ack_block;
   logic [15:0] write_len;
   logic        done_res;
   logic        failed;
   logic        may_lack_options;

   modport source (
      output valid, action, ack_block, write_len, done_res, failed, may_lack_options,
      input  ready
   );
   modport sink (
      input  valid, action, ack_block, write_len, done_res, failed, may_lack_options,
      output ready
   );
endinterface : trr_rsp_if

interface trr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface : trr_csr_if
`default_nettype wire

// ===== rtl/trr_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TFTP read receiver transfer core
// Holds the transfer state and computes the result of one registered word.
// ----------------------------------------------------------------------------
module trr_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   step,
   input  trr_pkg::cfg_type      cfg,
   input  trr_pkg::req_item_type item,
   output trr_pkg::rsp_item_type res
);

   logic [15:0] expected_block_ff, expected_block_in;
   logic        first_receive_ff, first_receive_in;
   logic [47:0] server_peer_ff, server_peer_in;
   logic [15:0] cur_block_size_ff, cur_block_size_in;
   logic [7:0]  retry_count_ff, retry_count_in;
   logic        last_was_ack_ff, last_was_ack_in;
   logic [15:0] last_ack_block_ff, last_ack_block_in;
   logic [31:0] bytes_total_ff, bytes_total_in;
   logic [31:0] expected_size_ff, expected_size_in;
   logic        finished_ff, finished_in;

   logic [31:0] bytes_sum;

   assign bytes_sum = bytes_total_ff + {16'd0, item.payload_len};

   always_comb begin
      expected_block_in = expected_block_ff;
      first_receive_in  = first_receive_ff;
      server_peer_in    = server_peer_ff;
      cur_block_size_in = cur_block_size_ff;
      retry_count_in    = retry_count_ff;
      last_was_ack_in   = last_was_ack_ff;
      last_ack_block_in = last_ack_block_ff;
      bytes_total_in    = bytes_total_ff;
      expected_size_in  = expected_size_ff;
      finished_in       = finished_ff;
      res               = '0;
      res.action        = trr_pkg::ACT_NONE;

      if (step) begin
         case (item.req_type)
            trr_pkg::REQ_START: begin
               expected_block_in = 16'd1;
               first_receive_in  = 1'b1;
               server_peer_in    = '0;
               cur_block_size_in = cfg.initial_block_size;
               retry_count_in    = '0;
               last_was_ack_in   = 1'b0;
               last_ack_block_in = '0;
               bytes_total_in    = '0;
               expected_size_in  = '0;
               finished_in       = 1'b0;
               res.action        = trr_pkg::ACT_RRQ;
            end
            trr_pkg::REQ_TIMEOUT: begin
               if (!finished_ff) begin
                  if (retry_count_ff >= cfg.max_retries) begin
                     finished_in          = 1'b1;
                     res.failed           = 1'b1;
                     res.may_lack_options = first_receive_ff;
                  end else begin
                     retry_count_in = retry_count_ff + 8'd1;
                     if (last_was_ack_ff) begin
                        res.action    = trr_pkg::ACT_ACK;
                        res.ack_block = last_ack_block_ff;
                     end else begin
                        res.action = trr_pkg::ACT_RRQ;
                     end
                  end
               end
            end
            trr_pkg::REQ_PACKET: begin
               if (!finished_ff) begin
                  retry_count_in = '0;
                  if (item.packet_empty) begin
                     finished_in = 1'b1;
                     res.failed  = 1'b1;
                  end else if (!first_receive_ff && item.peer_addr != server_peer_ff) begin
                     res.action = trr_pkg::ACT_UNKNOWN_ID;
                  end else begin
                     if (first_receive_ff) begin
                        server_peer_in = item.peer_addr;
                     end
                     first_receive_in = 1'b0;
                     case (item.opcode)
                        trr_pkg::OP_OACK: begin
                           // only the first receive may negotiate options
                           if (first_receive_ff) begin
                              if (item.oack_unrequested) begin
                                 res.action  = trr_pkg::ACT_BAD_OPTIONS;
                                 finished_in = 1'b1;
                                 res.failed  = 1'b1;
                              end else begin
                                 cur_block_size_in = item.oack_block_size;
                                 if (cfg.tsize_requested) begin
                                    expected_size_in = item.oack_tsize;
                                 end
                                 last_was_ack_in   = 1'b1;
                                 last_ack_block_in = '0;
                                 res.action        = trr_pkg::ACT_ACK;
                              end
                           end
                        end
                        trr_pkg::OP_DATA: begin
                           if (item.blk_num != expected_block_ff) begin
                              if (last_was_ack_ff) begin
                                 res.action    = trr_pkg::ACT_ACK;
                                 res.ack_block = last_ack_block_ff;
                              end else begin
                                 res.action = trr_pkg::ACT_RRQ;
                              end
                           end else begin
                              expected_block_in = expected_block_ff + 16'd1;
                              bytes_total_in    = bytes_sum;
                              res.write_len     = item.payload_len;
                              last_was_ack_in   = 1'b1;
                              last_ack_block_in = item.blk_num;
                              res.action        = trr_pkg::ACT_ACK;
                              res.ack_block     = item.blk_num;
                              // short block closes the transfer
                              if (item.payload_len < cur_block_size_ff) begin
                                 finished_in = 1'b1;
                                 if (cfg.tsize_requested && bytes_sum != expected_size_ff) begin
                                    res.failed = 1'b1;
                                 end else begin
                                    res.done_res = 1'b1;
                                 end
                              end
                           end
                        end
                        trr_pkg::OP_ERROR: begin
                           finished_in          = 1'b1;
                           res.failed           = 1'b1;
                           res.may_lack_options = first_receive_ff & cfg.options_requested;
                        end
                        default: begin
                           finished_in = 1'b1;
                           res.failed  = 1'b1;
                        end
                     endcase
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_block_ff <= 16'd1;
         first_receive_ff  <= 1'b1;
         server_peer_ff    <= '0;
         cur_block_size_ff <= trr_pkg::BLOCK_SIZE_RESET;
         retry_count_ff    <= '0;
         last_was_ack_ff   <= 1'b0;
         last_ack_block_ff <= '0;
         bytes_total_ff    <= '0;
         expected_size_ff  <= '0;
         finished_ff       <= 1'b0;
      end else begin
         expected_block_ff <= expected_block_in;
         first_receive_ff  <= first_receive_in;
         server_peer_ff    <= server_peer_in;
         cur_block_size_ff <= cur_block_size_in;
         retry_count_ff    <= retry_count_in;
         last_was_ack_ff   <= last_was_ack_in;
         last_ack_block_ff <= last_ack_block_in;
         bytes_total_ff    <= bytes_total_in;
         expected_size_ff  <= expected_size_in;
         finished_ff       <= finished_in;
      end
   end

endmodule : trr_core
`default_nettype wire

// ===== rtl/tftp_read_receiver_top.sv =====
// A word accepted into the input register has its result stored in the result register.
// Throughput: one word per cycle; the input register and the result register
// both advance whenever the result slot is empty or being taken.
// Reset (synchronous, active high) clears the transfer state, loads the csr
// defaults (block size 512, 5 retries, no options) and empties both stages.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TFTP read receiver top level
// Client-side TFTP read transfer control: acks, resends, retries, OACK, tsize.
// ----------------------------------------------------------------------------
module tftp_read_receiver_top (
   input  wire       clock,
   input  wire       reset,
   trr_req_if.sink   req,
   trr_rsp_if.source rsp,
   trr_csr_if.sink   csr
);

   trr_pkg::cfg_type      cfg_ff;
   trr_pkg::req_item_type item_ff;
   trr_pkg::req_item_type item_in;
   trr_pkg::rsp_item_type res;
   trr_pkg::rsp_item_type rsp_data_ff;
   logic                  item_valid_ff;
   logic                  rsp_valid_ff;
   logic                  advance;

   // csr writes are always taken
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_block_size <= trr_pkg::BLOCK_SIZE_RESET;
         cfg_ff.max_retries        <= trr_pkg::MAX_RETRIES_RESET;
         cfg_ff.options_requested  <= 1'b0;
         cfg_ff.tsize_requested    <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            trr_pkg::CSR_INITIAL_BLOCK_SIZE: cfg_ff.initial_block_size <= csr.data;
            trr_pkg::CSR_MAX_RETRIES:        cfg_ff.max_retries        <= csr.data[7:0];
            trr_pkg::CSR_OPTIONS_REQUESTED:  cfg_ff.options_requested  <= csr.data[0];
            trr_pkg::CSR_TSIZE_REQUESTED:    cfg_ff.tsize_requested    <= csr.data[0];
            default: begin
            end
         endcase
      end
   end

   assign advance   = item_valid_ff & (~rsp_valid_ff | rsp.ready);
   assign req.ready = ~item_valid_ff | advance;

   always_comb begin
      item_in.req_type         = req.req_type;
      item_in.opcode           = req.opcode;
      item_in.blk_num          = req.blk_num;
      item_in.payload_len      = req.payload_len;
      item_in.packet_empty     = req.packet_empty;
      item_in.peer_addr        = req.peer_addr;
      item_in.oack_block_size  = req.oack_block_size;
      item_in.oack_unrequested = req.oack_unrequested;
      item_in.oack_tsize       = req.oack_tsize;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req.ready) begin
            item_valid_ff <= req.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_data_ff <= res;
      end
   end

   trr_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .cfg   (cfg_ff),
      .item  (item_ff),
      .res   (res)
   );

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.action           = rsp_data_ff.action;
   assign rsp.ack_block        = rsp_data_ff.ack_block;
   assign rsp.write_len        = rsp_data_ff.write_len;
   assign rsp.done_res         = rsp_data_ff.done_res;
   assign rsp.failed           = rsp_data_ff.failed;
   assign rsp.may_lack_options = rsp_data_ff.may_lack_options;

endmodule : tftp_read_receiver_top
`default_nettype wire
